>>> rtl/csd_pkg.sv
package csd_pkg;

    // accumulator width and the widened sum used for the overflow check
    localparam int unsigned ACC_W = 32;
    localparam int unsigned SUM_W = 34;
    localparam logic [SUM_W-1:0] ACC_MAX = {{(SUM_W-ACC_W){1'b0}}, {ACC_W{1'b1}}};

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture an accepted input item
        logic mul;       // square the difference, set up the divider
        logic div_step;  // one restoring division step
        logic acc;       // add the term, emit the result on a last pair
    } csd_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic zero_denom;  // both samples are zero
        logic div_last;    // final quotient bit is being produced
        logic last;        // captured item carries the last mark
        logic out_free;    // output register can take a result this cycle
    } csd_stat_t;

endpackage

>>> rtl/chi_square_distance_accumulator_core.sv
// chi-square distance accumulator, one element pair at a time
// each pair is captured, squared, divided by the bit-serial restoring divider and then accumulated;
// a pair of two zeros skips the divider; a last pair waits in the accumulate step until the
// output register is free, and its result is then registered with tvalid on the output
// the divider gives one quotient bit a cycle; a new pair is taken only once the last one is through
// the output register holds a result while the next pair is taken in
// reset (rst_n low, asynchronous) clears the running sum, the overflow flag and the output valid flag
module chi_square_distance_accumulator_core #(
    parameter int unsigned SAMPLE_WIDTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // a_value [SAMPLE_WIDTH-1:0], b_value [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH], zero fill
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,
    input  logic                                   s_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // distance [31:0]
    output logic [csd_pkg::ACC_W-1:0]              m_tdata,
    // saturated [0]
    output logic                                   m_tuser
);

    localparam int unsigned SW = SAMPLE_WIDTH;

    csd_pkg::csd_cmd_t  cmd;
    csd_pkg::csd_stat_t stat;

    // sequencing
    csd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and accumulation
    csd_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .a_in          (s_tdata[SW-1:0]),
        .b_in          (s_tdata[2*SW-1:SW]),
        .last_in       (s_tlast),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_distance  (m_tdata),
        .out_saturated (m_tuser)
    );

    // a result appears only right after a last pair was accumulated
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.acc && stat.last))
        else $error("result without a last pair");

    // a saturated result must read as the clamp value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == {csd_pkg::ACC_W{1'b1}}))
        else $error("saturated flag with unclamped distance");

    // a last pair is never folded in while the output register holds a result not being taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.acc && stat.last) |-> stat.out_free)
        else $error("result overwritten");

endmodule

>>> rtl/csd_ctrl.sv
module csd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  csd_pkg::csd_stat_t  stat,
    output csd_pkg::csd_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_ACC  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and command decode
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (stat.zero_denom)
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                // a last pair waits until the output register is free
                if (!stat.last || stat.out_free)
                begin
                    cmd.acc    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/csd_datapath.sv
module csd_datapath #(
    parameter int unsigned SAMPLE_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [SAMPLE_WIDTH-1:0]       a_in,
    input  logic [SAMPLE_WIDTH-1:0]       b_in,
    input  logic                          last_in,
    input  csd_pkg::csd_cmd_t             cmd,
    output csd_pkg::csd_stat_t            stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [csd_pkg::ACC_W-1:0]     out_distance,
    output logic                          out_saturated
);

    localparam int unsigned SW    = SAMPLE_WIDTH;
    localparam int unsigned CNT_W = $clog2(SW + 1);

    // captured item
    logic [SW-1:0] a_reg;
    logic [SW-1:0] b_reg;
    logic          last_reg;

    // divider state
    logic [SW:0]      denom_reg;
    logic [SW:0]      rem_reg;
    logic [SW:0]      rem_next;
    logic [SW:0]      dvd_reg;
    logic [SW:0]      quo_reg;
    logic             zero_reg;
    logic [CNT_W-1:0] cnt_reg;

    // accumulator and output register
    logic [csd_pkg::ACC_W-1:0] sum_reg;
    logic [csd_pkg::ACC_W-1:0] sum_next;
    logic                      ovf_reg;
    logic                      ovf_next;
    logic [csd_pkg::ACC_W-1:0] out_dist_reg;
    logic                      out_sat_reg;
    logic                      out_valid_reg;

    // magnitudes, difference and square
    logic [SW:0]     a_ext;
    logic [SW:0]     b_ext;
    logic [SW:0]     abs_a;
    logic [SW:0]     abs_b;
    logic [SW:0]     denom;
    logic [SW:0]     diff;
    logic [SW:0]     mag_d;
    logic [2*SW-1:0] prod;

    // division step
    logic [SW+1:0] rem_shift;
    logic          rem_ge;

    // accumulate
    logic [csd_pkg::SUM_W-1:0] total;
    logic                      over;

    assign a_ext = {a_reg[SW-1], a_reg};
    assign b_ext = {b_reg[SW-1], b_reg};
    assign abs_a = a_ext[SW] ? (~a_ext + 1'b1) : a_ext;
    assign abs_b = b_ext[SW] ? (~b_ext + 1'b1) : b_ext;
    assign denom = abs_a + abs_b;
    assign diff  = a_ext - b_ext;
    assign mag_d = diff[SW] ? (~diff + 1'b1) : diff;
    assign prod  = (2*SW)'(mag_d[SW-1:0]) * (2*SW)'(mag_d[SW-1:0]);

    // restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, dvd_reg[SW]};
    assign rem_ge    = rem_shift >= {1'b0, denom_reg};
    assign rem_next  = rem_ge ? (SW+1)'(rem_shift - {1'b0, denom_reg})
                              : rem_shift[SW:0];

    // saturating add of the term
    assign total = {{(csd_pkg::SUM_W-csd_pkg::ACC_W){1'b0}}, sum_reg}
                 + (zero_reg ? '0 : csd_pkg::SUM_W'(quo_reg));
    assign over  = total > csd_pkg::ACC_MAX;

    always_comb
    begin
        if (over)
        begin
            sum_next = {csd_pkg::ACC_W{1'b1}};
            ovf_next = 1'b1;
        end
        else
        begin
            sum_next = total[csd_pkg::ACC_W-1:0];
            ovf_next = ovf_reg;
        end
    end

    // item capture, divider and output data registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg    <= a_in;
            b_reg    <= b_in;
            last_reg <= last_in;
        end
        if (cmd.mul)
        begin
            denom_reg <= denom;
            zero_reg  <= (denom == '0);
            rem_reg   <= {2'b00, prod[2*SW-1:SW+1]};
            dvd_reg   <= prod[SW:0];
            quo_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[SW-1:0], 1'b0};
            quo_reg <= {quo_reg[SW-1:0], rem_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.acc && last_reg)
        begin
            out_dist_reg <= sum_next;
            out_sat_reg  <= ovf_next;
        end
    end

    // accumulator and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc)
            begin
                if (last_reg)
                begin
                    sum_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    ovf_reg <= ovf_next;
                end
            end
            if (cmd.acc && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // status to the controller
    assign stat.zero_denom = (a_reg == '0) && (b_reg == '0);
    assign stat.div_last   = (cnt_reg == CNT_W'(SW));
    assign stat.last       = last_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_distance  = out_dist_reg;
    assign out_saturated = out_sat_reg;

endmodule
